@@ hdl/spra_pkg.sv @@
// Shared types, constants and the fixed ray table for the sliding ray attack core.
// No dependencies; imported by spra_cell and sliding_piece_ray_attacks_core.
package spra_pkg;

   localparam int LANES       = 4;
   localparam int SQ_W        = 6;
   localparam int KIND_W      = 3;
   localparam int BOARD_W     = 64;
   localparam int DIRS        = 8;
   localparam int DIR_W       = 3;
   localparam int SQUARES     = 64;
   localparam int ROM_DEPTH   = DIRS * SQUARES;
   localparam int ROM_AW      = DIR_W + SQ_W;

   // stream widths: tdata rounded up to whole bytes
   localparam int REQ_BITS    = SQ_W + LANES * BOARD_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = LANES * BOARD_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // piece kinds that see anything
   localparam logic [KIND_W-1:0] KIND_BISHOP = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ROOK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUEEN  = 3'd4;

   // ray directions; bit 2 set marks a diagonal
   localparam logic [DIR_W-1:0] DIR_UP       = 3'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_UP_RIGHT = 3'd4;
   localparam logic [DIR_W-1:0] DIR_UP_LEFT  = 3'd5;

   typedef logic [BOARD_W-1:0]            board_type;
   typedef logic [LANES-1:0][BOARD_W-1:0] lane_boards_type;
   typedef logic [ROM_DEPTH-1:0][BOARD_W-1:0] ray_rom_type;

   // one pipeline slot as it travels down the chain
   typedef struct packed {
      logic [SQ_W-1:0]   square;
      logic [KIND_W-1:0] piece_kind;
      lane_boards_type   occupancy;
      lane_boards_type   vision;
   } stage_type;

   // ray masks, entry dir*64+square; dirs: up, right, down, left,
   // up-right, up-left, down-right, down-left; origin excluded
   function automatic ray_rom_type build_ray_rom();
      ray_rom_type rom;
      int          dr [DIRS];
      int          df [DIRS];
      int          r;
      int          f;
      dr = '{1, 0, -1, 0, 1, 1, -1, -1};
      df = '{0, 1, 0, -1, 1, -1, 1, -1};
      rom = '0;
      for (int d = 0; d < DIRS; d++) begin
         for (int s = 0; s < SQUARES; s++) begin
            for (int k = 1; k < 8; k++) begin
               r = s / 8 + k * dr[d];
               f = s % 8 + k * df[d];
               if (r >= 0 && r < 8 && f >= 0 && f < 8) begin
                  rom[d * SQUARES + s][r * 8 + f] = 1'b1;
               end
            end
         end
      end
      return rom;
   endfunction

   localparam ray_rom_type RAY_ROM = build_ray_rom();

   function automatic board_type reverse_board(input board_type b);
      board_type r;
      for (int i = 0; i < BOARD_W; i++) begin
         r[i] = b[BOARD_W-1-i];
      end
      return r;
   endfunction

endpackage

@@ hdl/spra_cell.sv @@
// One chain cell: casts a single ray direction on every lane and registers the slot.
// Depends on spra_pkg (stage_type, RAY_ROM, kind codes).
module spra_cell
   import spra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DIR_W-1:0] dir,
   input  logic             up_valid,
   output logic             up_ready,
   input  stage_type        up_slot,
   output logic             dn_valid,
   input  logic             dn_ready,
   output stage_type        dn_slot
);

   logic      valid_ff;
   stage_type slot_ff;
   stage_type slot_in;
   board_type ray;
   logic      ortho;
   logic      diag;
   logic      use_dir;
   logic      ascending;

   assign ortho     = (up_slot.piece_kind == KIND_ROOK)   || (up_slot.piece_kind == KIND_QUEEN);
   assign diag      = (up_slot.piece_kind == KIND_BISHOP) || (up_slot.piece_kind == KIND_QUEEN);
   assign use_dir   = dir[2] ? diag : ortho;
   // up, right, up-right and up-left run toward higher indexes
   assign ascending = (dir == DIR_UP) || (dir == DIR_RIGHT) ||
                      (dir == DIR_UP_RIGHT) || (dir == DIR_UP_LEFT);
   assign ray       = RAY_ROM[{dir, up_slot.square}];

   always_comb begin
      board_type hit;
      board_type hit_r;
      board_type keep;
      slot_in = up_slot;
      for (int l = 0; l < LANES; l++) begin
         hit   = ray & up_slot.occupancy[l];
         // keep everything up to and including the nearest blocker;
         // with no blocker x ^ (x - 1) is all ones and the whole ray stays
         hit_r = reverse_board(hit);
         if (ascending) begin
            keep = hit ^ (hit - board_type'(1));
         end else begin
            keep = reverse_board(hit_r ^ (hit_r - board_type'(1)));
         end
         if (use_dir) begin
            slot_in.vision[l] = up_slot.vision[l] | (ray & keep);
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         slot_ff <= slot_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_slot  = slot_ff;

endmodule

@@ hdl/sliding_piece_ray_attacks_core.sv @@
// Top level of the sliding ray attack core: stream ports and a chain of eight ray cells.
// Depends on spra_pkg and spra_cell.
//
// Takes an origin square, a piece kind and one occupancy board per lane, and returns
// per lane the squares a bishop (kind 2), rook (kind 3) or queen (kind 4) on that square
// sees, each ray stopping at and including its first occupied square; other kinds give
// zero. Square 0 is a1, +8 is one rank up, +1 one file right. The work runs through a
// chain of eight cells, one per ray direction, each ORing its ray into the running result
// and passing the slot on. One transfer is taken per clock while the chain is not stalled
// full; one register per cell, so each request moves through all cell registers in order.
// The last cell's register drives the response; a stalled response backs up only as far as
// the chain is full, so requests are still taken while bubbles remain. No configuration,
// no clearing pass after reset.
module sliding_piece_ray_attacks_core
   import spra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] square, then occupancy_lane0..3 at 64 bits each from bit 6, zero pad on top
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] piece_kind
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // vision_lane0..3 at 64 bits each from bit 0
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   stage_type            slot   [DIRS+1];
   stage_type            head_slot;
   logic [DIRS:0]        valid;
   logic [DIRS:0]        ready;
   logic                 origin_seen;
   logic                 kind_sees;

   // unpack the request into the head slot; vision starts empty
   always_comb begin
      head_slot.square     = req_tdata[SQ_W-1:0];
      head_slot.piece_kind = req_tuser;
      for (int l = 0; l < LANES; l++) begin
         head_slot.occupancy[l] = req_tdata[SQ_W + l*BOARD_W +: BOARD_W];
      end
      head_slot.vision = '0;
   end

   assign slot[0]    = head_slot;
   assign valid[0]   = req_tvalid;
   assign req_tready = ready[0];

   // one cell per direction, cell i casts direction i
   for (genvar i = 0; i < DIRS; i++) begin : g_cell
      spra_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .dir      (DIR_W'(i)),
         .up_valid (valid[i]),
         .up_ready (ready[i]),
         .up_slot  (slot[i]),
         .dn_valid (valid[i+1]),
         .dn_ready (ready[i+1]),
         .dn_slot  (slot[i+1])
      );
   end

   assign ready[DIRS] = rsp_tready;
   assign rsp_tvalid  = valid[DIRS];

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_BITS-1:0] = slot[DIRS].vision;
   end

   // checks
   always_comb begin
      origin_seen = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         origin_seen = origin_seen | slot[DIRS].vision[l][slot[DIRS].square];
      end
   end

   assign kind_sees = (slot[DIRS].piece_kind == KIND_BISHOP) ||
                      (slot[DIRS].piece_kind == KIND_ROOK)   ||
                      (slot[DIRS].piece_kind == KIND_QUEEN);

   // the origin never lies on its own rays
   a_no_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !origin_seen)
      else $error("origin square reported visible");

   // non-sliding kinds see nothing
   a_blind_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !kind_sees) |-> (slot[DIRS].vision == '0))
      else $error("vision for a kind that sees nothing");

   // requests are refused only when every cell holds a slot
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (valid[DIRS:1] == '1) && !rsp_tready)
      else $error("request refused with room in the chain");

   // a stalled slot at the input of the last cell is held unchanged
   a_hold_tail: assert property (@(posedge clock) disable iff (reset)
      (valid[DIRS-1] && !ready[DIRS-1]) |=> valid[DIRS-1] && $stable(slot[DIRS-1]))
      else $error("stalled slot lost or changed");

endmodule

@@ tb/sliding_piece_ray_attacks_core_test.sv @@
// Self-checking testbench for the sliding ray attack core: stream driver, response monitor
// and a walking-ray predictor of per-lane vision. Depends on spra_pkg and the core RTL.
`timescale 1ns / 1ps

module sliding_piece_ray_attacks_core_test;
   import spra_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int TAIL_ITEMS     = 200;   // last queries go out with no idling
   localparam int RANDOM_ITEMS   = 1750;
   localparam int DRAIN_CYCLES   = 24;    // eight-stage chain plus margin

   typedef struct {
      logic [SQ_W-1:0]   square;
      logic [KIND_W-1:0] kind;
      lane_boards_type   occupancy;
   } ray_query_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ray_query_type   pending_queries[$];
   lane_boards_type expected_vision[$];

   logic req_taken   = 1'b0;  // query transfer seen at the last rising edge
   logic quiet_tail  = 1'b0;
   int   send_gap    = 0;
   int   stall_left  = 0;
   int   gap_pct     = 10;
   int   stall_pct   = 10;
   int   ready_turns = 0;
   int   idle_cycles = 0;
   int   mismatch_count = 0;

   always #10 clock = ~clock;

   sliding_piece_ray_attacks_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Walk each enabled direction outward from the origin; stop after the first occupied
   // square, keeping it. Origin itself never lands in the mask.
   function automatic board_type visible_squares(input logic [SQ_W-1:0] square,
                                                  input logic [KIND_W-1:0] kind,
                                                  input board_type occ);
      board_type vis;
      int        s;
      int        r;
      int        f;
      int        dr;
      int        df;
      bit        ortho;
      bit        diag;
      bit        blocked;
      s     = square;
      ortho = (kind == KIND_ROOK) || (kind == KIND_QUEEN);
      diag  = (kind == KIND_BISHOP) || (kind == KIND_QUEEN);
      vis   = '0;
      // direction order: up, right, down, left, up-right, up-left, down-right, down-left
      for (int d = 0; d < 8; d++) begin
         dr = (d == 0 || d == 4 || d == 5) ? 1 : (d == 2 || d == 6 || d == 7) ? -1 : 0;
         df = (d == 1 || d == 4 || d == 6) ? 1 : (d == 3 || d == 5 || d == 7) ? -1 : 0;
         if ((d < 4) ? ortho : diag) begin
            r = s / 8 + dr;
            f = s % 8 + df;
            blocked = 1'b0;
            while (!blocked && r >= 0 && r < 8 && f >= 0 && f < 8) begin
               vis[r * 8 + f] = 1'b1;
               blocked = occ[r * 8 + f];
               r += dr;
               f += df;
            end
         end
      end
      return vis;
   endfunction

   function automatic lane_boards_type lane_vision(input logic [SQ_W-1:0] square,
                                                   input logic [KIND_W-1:0] kind,
                                                   input lane_boards_type occ);
      lane_boards_type vis;
      for (int lane = 0; lane < LANES; lane++) begin
         vis[lane] = visible_squares(square, kind, occ[lane]);
      end
      return vis;
   endfunction

   // Mix of empty, full, sparse, dense, single-square and plain random boards.
   function automatic board_type random_board();
      board_type b;
      case ($urandom_range(0, 7))
         0: b = '0;
         1: b = '1;
         2: b = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         3: b = {$urandom, $urandom} | {$urandom, $urandom};
         4: b = board_type'(1) << $urandom_range(0, 63);
         default: b = {$urandom, $urandom};
      endcase
      return b;
   endfunction

   task automatic add_query(input logic [SQ_W-1:0] square, input logic [KIND_W-1:0] kind,
                            input lane_boards_type occ);
      ray_query_type q;
      q.square    = square;
      q.kind      = kind;
      q.occupancy = occ;
      pending_queries.push_back(q);
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- query driver
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
   end

   always @(negedge clock) begin : drive_queries
      ray_query_type q;
      if (!reset) begin
         quiet_tail <= (pending_queries.size() < TAIL_ITEMS);
         if (req_tvalid && !req_taken) begin
            // hold the offered query until its transfer
         end else if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (pending_queries.size() > 0) begin
            if (pending_queries.size() % 128 == 0) begin
               // alternate busy stretches, light gaps and heavy gaps
               case ($urandom_range(0, 2))
                  0: gap_pct = 0;
                  1: gap_pct = 8;
                  default: gap_pct = 30;
               endcase
            end
            q = pending_queries.pop_front();
            req_tdata  <= {{(REQ_DATA_W - REQ_BITS){1'b0}}, q.occupancy, q.square};
            req_tuser  <= q.kind;
            req_tvalid <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
               send_gap <= $urandom_range(1, 14);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- response backpressure
   always @(negedge clock) begin : drive_ready
      if (!reset) begin
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
            ready_turns++;
            if (ready_turns % 150 == 0) begin
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 8;
                  default: stall_pct = 30;
               endcase
            end
            if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
               stall_left <= $urandom_range(1, 14);
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor and checker
   always @(posedge clock) begin : check_vision
      lane_boards_type want;
      if (!reset) begin
         // response first so a same-edge query never lines up against itself
         if (rsp_tvalid && rsp_tready) begin
            if (expected_vision.size() == 0) begin
               report_mismatch($sformatf("response transfer with nothing expected: %h",
                                         rsp_tdata));
            end else begin
               want = expected_vision.pop_front();
               for (int lane = 0; lane < LANES; lane++) begin
                  if (rsp_tdata[lane * BOARD_W +: BOARD_W] !== want[lane]) begin
                     report_mismatch($sformatf("vision_lane%0d got %h want %h", lane,
                                               rsp_tdata[lane * BOARD_W +: BOARD_W],
                                               want[lane]));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_vision.push_back(lane_vision(req_tdata[SQ_W-1:0], req_tuser,
                                                  req_tdata[SQ_W +: LANES * BOARD_W]));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus and end of run
   initial begin : run_test
      lane_boards_type occ;
      logic [SQ_W-1:0]   sq;
      logic [KIND_W-1:0] kind;
      int                pick;

      // every piece kind on a central square: empty, full and random lanes
      for (int k = 0; k < 8; k++) begin
         occ = {random_board(), {$urandom, $urandom}, {BOARD_W{1'b1}}, {BOARD_W{1'b0}}};
         add_query(6'd27, KIND_W'(k), occ);
      end
      // corners with open and fully blocked boards
      add_query(6'd0,  KIND_QUEEN, '0);
      add_query(6'd7,  KIND_QUEEN, '1);
      add_query(6'd56, KIND_QUEEN, {4{{BOARD_W{1'b1}} ^ (board_type'(1) << 56)}});
      add_query(6'd63, KIND_QUEEN, '0);
      // occupied origin only: whole rays stay visible
      add_query(6'd36, KIND_QUEEN, {4{board_type'(1) << 36}});
      add_query(6'd9,  KIND_BISHOP, {4{board_type'(1) << 9}});
      // edge squares with random blockers and the all-ones occupancy pattern
      add_query(6'd3,  KIND_ROOK,   {random_board(), random_board(), {BOARD_W{1'b1}},
                                     {BOARD_W{1'b0}}});
      add_query(6'd40, KIND_ROOK,   {{$urandom, $urandom}, {BOARD_W{1'b1}}, random_board(),
                                     {BOARD_W{1'b0}}});
      add_query(6'd31, KIND_BISHOP, {{BOARD_W{1'b0}}, random_board(), {BOARD_W{1'b1}},
                                     {$urandom, $urandom}});
      add_query(6'd60, KIND_BISHOP, {{BOARD_W{1'b1}}, {BOARD_W{1'b0}}, random_board(),
                                     random_board()});
      add_query(6'd63, KIND_ROOK,   '1);
      // blockers at ray ends, on the board rim
      add_query(6'd18, KIND_QUEEN,  {4{64'h8100_0000_0000_0081}});
      add_query(6'd45, KIND_QUEEN,  {4{64'hFF81_8181_8181_81FF}});

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sq   = SQ_W'($urandom_range(0, 63));
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            kind = KIND_BISHOP;
         end else if (pick < 6) begin
            kind = KIND_ROOK;
         end else if (pick < 8) begin
            kind = KIND_QUEEN;
         end else begin
            kind = KIND_W'($urandom_range(0, 7));
         end
         for (int lane = 0; lane < LANES; lane++) begin
            occ[lane] = random_board();
         end
         add_query(sq, kind, occ);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all queries transferred and every expected response seen
      while (pending_queries.size() != 0 || req_tvalid || expected_vision.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_vision.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
